// ----- hw/rtl/fpa_pkg.sv -----
`default_nettype none
package fpa_pkg;
    localparam int FracBits  = 8;
    localparam int WordWidth = 32;
    localparam int DpWidth   = (WordWidth > 32) ? 32 : WordWidth;
    localparam int FieldW    = 32;
    localparam int QBits     = DpWidth + FracBits + 1;
    localparam int NumCells  = QBits;
    // numerator 2*|a|<<F + |b| stays below 2^(DpWidth+FracBits+1)
    localparam int MagW      = DpWidth + FracBits + 1;

    typedef enum logic [3:0] {
        FN_ADD = 4'd0, FN_SUB = 4'd1, FN_MUL = 4'd2, FN_DIV = 4'd3,
        FN_MIN = 4'd4, FN_MAX = 4'd5, FN_INC = 4'd6, FN_DEC = 4'd7,
        FN_FROM_INT = 4'd8, FN_TO_INT = 4'd9
    } t_func;

    typedef enum logic [1:0] {
        ERR_OK = 2'd0, ERR_OVF = 2'd1, ERR_DIV0 = 2'd2
    } t_err;

    // Per-item context that rides the divider chain.
    typedef struct packed {
        logic                       vld;
        logic [3:0]                 func;
        logic signed [FieldW-1:0]   a;
        logic signed [FieldW-1:0]   b;
        logic signed [FieldW-1:0]   early;   // result of non-divide ops
        logic [1:0]                 early_err;
        logic                       neg;
        logic [MagW-1:0]            den;     // 2*|b|
        logic [MagW-1:0]            rem;
        logic [MagW-1:0]            num;     // 2*|a|<<F + |b|, shifted out MSB first
        logic [QBits-1:0]           quo;
    } t_cell;

    function automatic logic signed [FieldW-1:0] sat_ext(
        input logic signed [MagW+DpWidth:0] v, output logic ovf);
        logic signed [MagW+DpWidth:0] hi;
        logic signed [MagW+DpWidth:0] lo;
        begin
            hi = (MagW+DpWidth+1)'((64'sd1 <<< (DpWidth-1)) - 64'sd1);
            lo = -hi - 1;
            ovf = 1'b0;
            if (v > hi) begin
                ovf = 1'b1;
                sat_ext = FieldW'(hi);
            end else if (v < lo) begin
                ovf = 1'b1;
                sat_ext = FieldW'(lo);
            end else begin
                sat_ext = FieldW'(v);
            end
        end
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/fpa_cell.sv -----
`default_nettype none
module fpa_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire fpa_pkg::t_cell  i_prev,
    output fpa_pkg::t_cell       o_next
);
    import fpa_pkg::*;

    t_cell n_c;
    t_cell r_c;
    logic [MagW:0] w_trial;
    logic [MagW:0] w_diff;

    // one restoring-division step: bring in one numerator bit
    always_comb begin
        n_c     = i_prev;
        w_trial = {i_prev.rem, i_prev.num[MagW-1]};
        w_diff  = w_trial - {1'b0, i_prev.den};
        n_c.num = {i_prev.num[MagW-2:0], 1'b0};
        if (!w_diff[MagW]) begin
            n_c.rem = w_diff[MagW-1:0];
            n_c.quo = {i_prev.quo[QBits-2:0], 1'b1};
        end else begin
            n_c.rem = w_trial[MagW-1:0];
            n_c.quo = {i_prev.quo[QBits-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.vld <= 1'b0;
        end else if (i_en) begin
            r_c <= n_c;
        end
    end

    assign o_next = r_c;
endmodule
`default_nettype wire

// ----- hw/rtl/fpa_front.sv -----
`default_nettype none
module fpa_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_vld,
    input  wire logic [3:0]                    i_func,
    input  wire logic signed [fpa_pkg::FieldW-1:0] i_a,
    input  wire logic signed [fpa_pkg::FieldW-1:0] i_b,
    output fpa_pkg::t_cell                     o_cell
);
    import fpa_pkg::*;

    localparam int XW = MagW + DpWidth + 1;

    // stage 1: take the low DpWidth bits of each operand, multiply, register
    logic                        r_vld;
    logic [3:0]                  r_func;
    logic signed [DpWidth-1:0]   r_a, r_b;
    logic signed [2*DpWidth-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_func <= i_func;
            r_a    <= i_a[DpWidth-1:0];
            r_b    <= i_b[DpWidth-1:0];
            r_prod <= $signed(i_a[DpWidth-1:0]) * $signed(i_b[DpWidth-1:0]);
        end
    end

    logic signed [XW-1:0] w_a, w_b, w_v, w_pm;
    logic [2*DpWidth-1:0] w_pmag;
    logic [DpWidth-1:0]   w_amag, w_bmag;
    logic                 w_ovf;
    t_cell                n_cell;
    t_cell                r_cell;

    always_comb begin
        w_a    = XW'(r_a);
        w_b    = XW'(r_b);
        w_pmag = r_prod[2*DpWidth-1] ? (2*DpWidth)'(-r_prod) : r_prod;
        w_pm   = $signed(XW'((w_pmag + (2*DpWidth)'(1 << (FracBits-1))) >> FracBits));
        w_amag = r_a[DpWidth-1] ? DpWidth'(-r_a) : r_a;
        w_bmag = r_b[DpWidth-1] ? DpWidth'(-r_b) : r_b;
        w_v    = '0;
        n_cell = '0;
        n_cell.vld  = r_vld;
        n_cell.func = r_func;
        n_cell.a    = FieldW'(r_a);
        n_cell.b    = FieldW'(r_b);
        unique case (r_func)
            FN_ADD:      w_v = w_a + w_b;
            FN_SUB:      w_v = w_a - w_b;
            FN_MUL:      w_v = r_prod[2*DpWidth-1] ? -w_pm : w_pm;
            FN_MIN:      w_v = (r_a < r_b) ? w_a : w_b;
            FN_MAX:      w_v = (r_a < r_b) ? w_b : w_a;
            FN_INC:      w_v = w_a + XW'(1);
            FN_DEC:      w_v = w_a - XW'(1);
            FN_FROM_INT: w_v = w_a <<< FracBits;
            FN_TO_INT:   w_v = r_a[DpWidth-1] ? -XW'(w_amag >> FracBits)
                                              : XW'(w_amag >> FracBits);
            default:     w_v = '0;
        endcase
        n_cell.early     = sat_ext(w_v, w_ovf);
        n_cell.early_err = w_ovf ? ERR_OVF : ERR_OK;
        n_cell.neg       = r_a[DpWidth-1] ^ r_b[DpWidth-1];
        n_cell.den       = MagW'({w_bmag, 1'b0});
        n_cell.num       = (MagW'(w_amag) << (FracBits + 1)) + MagW'(w_bmag);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.vld <= 1'b0;
        end else if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;
endmodule
`default_nettype wire

// ----- hw/rtl/fixed_point_alu_top.sv -----
`default_nettype none
// channel | dir | handshake         | payload
// s_axis  | in  | tvalid/tready     | tdata: func, operand_a, operand_b
// m_axis  | out | tvalid/tready     | tdata: result, a_less, a_equal, a_greater, error_code
// One transaction per cycle sustained. The pipe is two front stages (multiply,
// then op select), one cell per quotient bit of the divider chain, then the
// output register. The whole pipe advances together; it stalls only when the
// output register is full and not taken.
// Synchronous active-low reset clears all valid bits.
module fixed_point_alu_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // [3:0] func, [35:4] operand_a, [67:36] operand_b
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata   // [31:0] result, 32 less, 33 equal, 34 greater,
                                            // [36:35] error_code
);
    import fpa_pkg::*;

    logic  w_en;
    t_cell w_chain [NumCells+1];
    logic  r_ovld;
    logic [39:0] r_odata;

    assign w_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (s_axis_tvalid),
        .i_func  (s_axis_tdata[3:0]),
        .i_a     (s_axis_tdata[35:4]),
        .i_b     (s_axis_tdata[67:36]),
        .o_cell  (w_chain[0])
    );

    for (genvar g = 0; g < NumCells; g++) begin : g_cell
        fpa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_prev  (w_chain[g]),
            .o_next  (w_chain[g+1])
        );
    end

    t_cell w_last;
    logic signed [MagW+DpWidth:0] w_q;
    logic signed [FieldW-1:0] w_res;
    logic  w_ovf;
    logic [1:0] w_err;
    logic  w_lt, w_eq;

    always_comb begin
        w_last = w_chain[NumCells];
        w_q    = (MagW+DpWidth+1)'(w_last.quo);
        if (w_last.neg) w_q = -w_q;
        w_res  = w_last.early;
        w_err  = w_last.early_err;
        w_ovf  = 1'b0;
        if (w_last.func == FN_DIV) begin
            if (w_last.b == '0) begin
                w_res = '0;
                w_err = ERR_DIV0;
            end else begin
                w_res = sat_ext(w_q, w_ovf);
                w_err = w_ovf ? ERR_OVF : ERR_OK;
            end
        end
        w_lt = w_last.a < w_last.b;
        w_eq = w_last.a == w_last.b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_en) begin
            r_ovld <= w_last.vld;
        end
        if (w_en) begin
            r_odata <= {3'b000, w_err, !w_lt && !w_eq, w_eq, w_lt, w_res};
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
endmodule
`default_nettype wire
